// File: rtl/core/cbq_pkg.sv
// Shared types and constants for the cascaded biquad filter.
// Used by the controller, the datapath and the top level. No dependencies.
package cbq_pkg;

  // Field widths and fixed-point format.
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 20;
  localparam int COEF_FRAC_BITS = 16;
  localparam int PROD_W         = COEF_W + SAMPLE_W;
  // Five products are summed, so three guard bits cover the growth.
  localparam int ACC_W          = PROD_W + 3;
  localparam int Q_W            = ACC_W - COEF_FRAC_BITS;
  localparam int CFG_IDX_W      = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_val_t;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0           = 3'd0,
    CFG_B1           = 3'd1,
    CFG_B2           = 3'd2,
    CFG_A1           = 3'd3,
    CFG_A2           = 3'd4,
    CFG_TWO_SECTIONS = 3'd5
  } cfg_idx_t;

  // Coefficient set shared by both sections.
  typedef struct packed {
    coef_val_t b0;
    coef_val_t b1;
    coef_val_t b2;
    coef_val_t a1;
    coef_val_t a2;
  } coef_t;

  // Product slot issued to the shared multiplier.
  typedef enum logic [2:0] {
    TAP_B0 = 3'd0,
    TAP_B1 = 3'd1,
    TAP_B2 = 3'd2,
    TAP_A1 = 3'd3,
    TAP_A2 = 3'd4
  } tap_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM,
    ST_MAC,
    ST_DRAIN,
    ST_COMMIT,
    ST_DONE
  } state_t;

  // Commands from the controller.
  typedef struct packed {
    logic load;        // capture the accepted input sample
    logic warm;        // warm-up step: load input history, clear the rest
    logic warm_first;  // first warm-up sample goes to x[n-2]
    logic mul;         // issue one product to the multiplier
    tap_t tap;
    logic acc_clr;     // start a new sum
    logic acc_add;     // add the registered product to the sum, or subtract it for a1 and a2
    logic commit;      // round, saturate and shift the section history
    logic sec;         // section being computed
    logic out_load;    // move the result into the output register
  } cmd_t;

  // Status seen by the controller.
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic two_sections;
  } status_t;

endpackage

// File: rtl/core/cbq_ctrl.sv
// Sequencer for the biquad filter: warm-up count, product slots and sections.
// Depends on cbq_pkg; drives the datapath through cmd_t.
module cbq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  cbq_pkg::status_t  status,
  output cbq_pkg::cmd_t     cmd,
  output logic              in_stall
);
  import cbq_pkg::*;

  state_t     state_r, state_nxt;
  tap_t       tap_r, tap_nxt;
  logic       sec_r, sec_nxt;
  logic [1:0] warm_cnt_r, warm_cnt_nxt;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      tap_r      <= TAP_B0;
      sec_r      <= 1'b0;
      warm_cnt_r <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      tap_r      <= tap_nxt;
      sec_r      <= sec_nxt;
      warm_cnt_r <= warm_cnt_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt    = state_r;
    tap_nxt      = tap_r;
    sec_nxt      = sec_r;
    warm_cnt_nxt = warm_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (status.in_valid) begin
          tap_nxt = TAP_B0;
          sec_nxt = 1'b0;
          if (warm_cnt_r != 2'd2) begin
            state_nxt = ST_WARM;
          end else begin
            state_nxt = ST_MAC;
          end
        end
      end
      ST_WARM: begin
        warm_cnt_nxt = warm_cnt_r + 2'd1;
        state_nxt    = ST_DONE;
      end
      ST_MAC: begin
        if (tap_r == TAP_A2) begin
          state_nxt = ST_DRAIN;
        end else begin
          tap_nxt = tap_t'(tap_r + 3'd1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!sec_r && status.two_sections) begin
          sec_nxt   = 1'b1;
          tap_nxt   = TAP_B0;
          state_nxt = ST_MAC;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd            = '0;
    cmd.tap        = tap_r;
    cmd.sec        = sec_r;
    cmd.warm_first = (warm_cnt_r == 2'd0);
    in_stall       = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.load = status.in_valid;
      end
      ST_WARM: begin
        cmd.warm = 1'b1;
      end
      ST_MAC: begin
        cmd.mul     = 1'b1;
        cmd.acc_clr = (tap_r == TAP_B0);
        cmd.acc_add = (tap_r != TAP_B0);
      end
      ST_DRAIN: begin
        cmd.acc_add = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/cbq_datapath.sv
// Biquad datapath: section histories, one shared multiplier, accumulator,
// rounding toward zero and 16-bit saturation. Depends on cbq_pkg.
module cbq_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  cbq_pkg::cmd_t     cmd,
  input  cbq_pkg::coef_t    coef,
  input  cbq_pkg::sample_t  sample_in,
  output cbq_pkg::sample_t  result
);
  import cbq_pkg::*;

  localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] SAT_MIN = Q_W'(-(2 ** (SAMPLE_W - 1)));
  localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((2 ** COEF_FRAC_BITS) - 1);

  // Section histories: index 0 is one sample back, index 1 two back.
  sample_t xh1_r [2];
  sample_t yh1_r [2];
  sample_t xh2_r [2];
  sample_t yh2_r [2];

  // Section input; holds the section result after commit.
  sample_t cur_x_r;

  logic signed [PROD_W-1:0] prod_r;
  logic                     neg_r;
  logic signed [ACC_W-1:0]  acc_r;

  coef_val_t                coef_sel;
  sample_t                  op_sel;
  logic signed [PROD_W-1:0] mul_w;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_biased;
  logic signed [Q_W-1:0]    quot;
  sample_t                  sat_q;

  // Operand selection for the current product slot.
  always_comb begin
    coef_sel = '0;
    op_sel   = '0;
    case (cmd.tap)
      TAP_B0: begin
        coef_sel = coef.b0;
        op_sel   = cur_x_r;
      end
      TAP_B1: begin
        coef_sel = coef.b1;
        op_sel   = cmd.sec ? xh2_r[0] : xh1_r[0];
      end
      TAP_B2: begin
        coef_sel = coef.b2;
        op_sel   = cmd.sec ? xh2_r[1] : xh1_r[1];
      end
      TAP_A1: begin
        coef_sel = coef.a1;
        op_sel   = cmd.sec ? yh2_r[0] : yh1_r[0];
      end
      TAP_A2: begin
        coef_sel = coef.a2;
        op_sel   = cmd.sec ? yh2_r[1] : yh1_r[1];
      end
      default: begin
        coef_sel = '0;
        op_sel   = '0;
      end
    endcase
  end

  assign mul_w    = coef_sel * op_sel;
  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // Truncate toward zero: bias negative sums before the arithmetic shift.
  assign acc_biased = acc_r + (acc_r[ACC_W-1] ? TRUNC_BIAS : '0);
  assign quot       = acc_biased[ACC_W-1:COEF_FRAC_BITS];

  // Saturate to the sample range.
  always_comb begin
    if (quot > SAT_MAX) begin
      sat_q = SAT_MAX[SAMPLE_W-1:0];
    end else if (quot < SAT_MIN) begin
      sat_q = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sat_q = quot[SAMPLE_W-1:0];
    end
  end

  // Multiplier output register and accumulator.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= mul_w;
      neg_r  <= (cmd.tap == TAP_A1) || (cmd.tap == TAP_A2);
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= neg_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

  // Section input and histories.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      xh1_r[0] <= '0;
      xh1_r[1] <= '0;
      yh1_r[0] <= '0;
      yh1_r[1] <= '0;
      xh2_r[0] <= '0;
      xh2_r[1] <= '0;
      yh2_r[0] <= '0;
      yh2_r[1] <= '0;
    end else if (cmd.load) begin
      cur_x_r <= sample_in;
    end else if (cmd.warm) begin
      if (cmd.warm_first) begin
        xh1_r[1] <= cur_x_r;
      end else begin
        xh1_r[0] <= cur_x_r;
      end
      yh1_r[0] <= '0;
      yh1_r[1] <= '0;
      xh2_r[0] <= '0;
      xh2_r[1] <= '0;
      yh2_r[0] <= '0;
      yh2_r[1] <= '0;
      cur_x_r  <= '0;
    end else if (cmd.commit) begin
      if (cmd.sec) begin
        xh2_r[1] <= xh2_r[0];
        xh2_r[0] <= cur_x_r;
        yh2_r[1] <= yh2_r[0];
        yh2_r[0] <= sat_q;
      end else begin
        xh1_r[1] <= xh1_r[0];
        xh1_r[0] <= cur_x_r;
        yh1_r[1] <= yh1_r[0];
        yh1_r[0] <= sat_q;
      end
      cur_x_r <= sat_q;
    end
  end

  assign result = cur_x_r;

endmodule

// File: rtl/core/cascaded_biquad_iir_filter.sv
// Cascaded direct-form-1 biquad filter, one or two sections, shared multiplier.
// Per section: product slots, drain, commit; the result then moves into the output register.
// A new sample is taken only after the last result has moved into the output register;
// the single multiplier computes the five products of each section in turn.
// Synchronous active-low reset clears coefficients, histories and warm-up count.
// Depends on cbq_pkg, cbq_ctrl and cbq_datapath.
module cascaded_biquad_iir_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cbq_pkg::sample_t                    in_sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cbq_pkg::sample_t                    out_sample_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbq_pkg::COEF_W-1:0]          cfg_data
);
  import cbq_pkg::*;

  coef_t   coef_r;
  logic    two_sections_r;
  logic    out_valid_r;
  sample_t out_sample_r;
  cmd_t    cmd;
  status_t status;
  sample_t dp_result;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r         <= '0;
      two_sections_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_B0:           coef_r.b0 <= cfg_data;
        CFG_B1:           coef_r.b1 <= cfg_data;
        CFG_B2:           coef_r.b2 <= cfg_data;
        CFG_A1:           coef_r.a1 <= cfg_data;
        CFG_A2:           coef_r.a2 <= cfg_data;
        CFG_TWO_SECTIONS: two_sections_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Status for the controller.
  always_comb begin
    status.in_valid     = in_valid;
    status.out_free     = !out_valid_r || !out_stall;
    status.two_sections = two_sections_r;
  end

  cbq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  cbq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .coef      (coef_r),
    .sample_in (in_sample_in),
    .result    (dp_result)
  );

  // Output register; a finished result waits here for its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_r <= dp_result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the cascaded biquad filter: a directed table, then random phases.
// Depends on cbq_pkg and cascaded_biquad_iir_filter; needs nothing else.
module tb;
  import cbq_pkg::*;

  localparam int RANDOM_TARGET = 1350;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 40;

  // Indexes past the last register; writes there must leave the filter untouched.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_TWO_SECTIONS + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_SPARE_LO + 1'b1;

  localparam sample_t   S_MAX = 16'sh7FFF;
  localparam sample_t   S_MIN = 16'sh8000;
  localparam coef_val_t C_MAX = 20'sh7FFFF;
  localparam coef_val_t C_MIN = 20'sh80000;
  localparam coef_val_t C_ONE = 20'sh10000;

  typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [COEF_W-1:0]      data;
    sample_t                x;
    bit                     typed;
    sample_t                want;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  sample_t              in_sample_in;
  logic                 out_valid;
  logic                 out_stall;
  sample_t              out_sample_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  // Shadow copy of the filter state and its registers.
  coef_t      coefs;
  logic       two_sec;
  logic [1:0] warm_cnt;
  sample_t    x_hist [4];
  sample_t    y_hist [4];

  sample_t    expected_samples [$];
  sample_t    want_sample;
  dir_row_t   dir_rows [$];

  int failures;
  int samples_sent;
  int samples_checked;
  int settings_used;
  int idle_level;
  bit calm;
  bit hold_req;

  cascaded_biquad_iir_filter DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One direct-form-1 section: exact sum, truncate toward zero, saturate, shift history.
  function automatic sample_t run_biquad(sample_t x, int base);
    longint acc;
    longint q;
    acc = longint'($signed(coefs.b0)) * longint'(x)
        + longint'($signed(coefs.b1)) * longint'(x_hist[base])
        + longint'($signed(coefs.b2)) * longint'(x_hist[base + 1])
        - longint'($signed(coefs.a1)) * longint'(y_hist[base])
        - longint'($signed(coefs.a2)) * longint'(y_hist[base + 1]);
    if (acc < 0) begin
      q = -((-acc) >>> COEF_FRAC_BITS);
    end else begin
      q = acc >>> COEF_FRAC_BITS;
    end
    if (q > longint'(S_MAX)) q = longint'(S_MAX);
    if (q < longint'(S_MIN)) q = longint'(S_MIN);
    x_hist[base + 1] = x_hist[base];
    x_hist[base]     = x;
    y_hist[base + 1] = y_hist[base];
    y_hist[base]     = sample_t'(q);
    return sample_t'(q);
  endfunction

  // Whole filter for one sample, including the two-sample warm-up after reset.
  function automatic sample_t filter_sample(sample_t x);
    sample_t r = '0;
    if (warm_cnt < 2) begin
      if (warm_cnt == 0) begin
        x_hist[1] = x;
      end else begin
        x_hist[0] = x;
      end
      y_hist[0] = '0;
      y_hist[1] = '0;
      x_hist[2] = '0;
      x_hist[3] = '0;
      y_hist[2] = '0;
      y_hist[3] = '0;
      warm_cnt++;
    end else begin
      r = run_biquad(x, 0);
      if (two_sec) r = run_biquad(r, 2);
    end
    return r;
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    dir_row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.data  = data;
    r.x     = '0;
    r.typed = 1'b0;
    r.want  = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_sample(sample_t x, bit typed, sample_t want);
    dir_row_t r;
    r.kind  = ROW_SAMPLE;
    r.idx   = '0;
    r.data  = '0;
    r.x     = x;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  // Half full-scale noise, the rest small audio-like values and some rail values.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      1, 2, 3: return sample_t'(int'($urandom_range(0, 1024)) - 512);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return C_MAX;
      1: return C_MIN;
      2: return C_ONE;
      default: return '0;
    endcase
  endfunction

  // Register write; returns at the next falling edge with cfg_valid still high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_B0:           coefs.b0 = data;
      CFG_B1:           coefs.b1 = data;
      CFG_B2:           coefs.b2 = data;
      CFG_A1:           coefs.a1 = data;
      CFG_A2:           coefs.a2 = data;
      CFG_TWO_SECTIONS: two_sec  = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Sample transfer with an optional idle burst ahead of it; the prediction is
  // queued when the block takes the sample.
  task automatic send_sample(input sample_t x, input bit typed, input sample_t want);
    int gap;
    sample_t predicted;
    cfg_valid <= 1'b0;
    if (!calm && idle_level != 0 && $urandom_range(0, 7) < idle_level) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= x;
    do @(posedge clk); while (in_stall);
    predicted = filter_sample(x);
    expected_samples.push_back(typed ? want : predicted);
    samples_sent++;
    @(negedge clk);
  endtask

  // Registers change only once every queued result has been delivered.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
  endtask

  // New coefficient set for a random phase.
  task automatic configure_phase();
    logic [COEF_W-1:0] vals [5];
    int mode;
    int a1;
    int a2;
    int lim;
    mode = $urandom_range(0, 5);
    settle();
    case (mode)
      3: begin
        for (int i = 0; i < 5; i++) vals[i] = COEF_W'($urandom());
      end
      4: begin
        for (int i = 0; i < 5; i++) vals[i] = pick_extreme();
      end
      5: begin
        // Pure feedforward with wide taps.
        for (int i = 0; i < 3; i++) vals[i] = COEF_W'($urandom());
        vals[3] = '0;
        vals[4] = '0;
      end
      default: begin
        // Stable pole pair, so the outputs stay mostly off the rails.
        for (int i = 0; i < 3; i++) vals[i] = COEF_W'(int'($urandom_range(0, 65536)) - 32768);
        a2  = int'($urandom_range(0, 116000)) - 58000;
        lim = 63000 + a2;
        a1  = int'($urandom_range(0, 2 * lim)) - lim;
        vals[3] = COEF_W'(a1);
        vals[4] = COEF_W'(a2);
      end
    endcase
    write_reg(CFG_B0, vals[0]);
    write_reg(CFG_B1, vals[1]);
    write_reg(CFG_B2, vals[2]);
    write_reg(CFG_A1, vals[3]);
    write_reg(CFG_A2, vals[4]);
    write_reg(CFG_TWO_SECTIONS, COEF_W'($urandom()));
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), COEF_W'($urandom()));
    end
    idle_level = $urandom_range(0, 3);
    settings_used++;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && idle_level != 0 && $urandom_range(0, 7) < idle_level) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Every result transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out: transfer with nothing expected, actual %0d", out_sample_out);
        failures++;
      end else begin
        want_sample = expected_samples.pop_front();
        samples_checked++;
        if (out_sample_out !== want_sample) begin
          $error("sample_out mismatch: expected %0d, actual %0d", want_sample, out_sample_out);
          failures++;
        end
      end
    end
  end

  // Main stimulus.
  initial begin
    int n;
    int phase;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    coefs        = '0;
    two_sec      = 1'b0;
    warm_cnt     = '0;
    for (int i = 0; i < 4; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    failures        = 0;
    samples_sent    = 0;
    samples_checked = 0;
    settings_used   = 0;
    idle_level      = 2;
    calm            = 1'b0;
    hold_req        = 1'b0;
    phase           = 0;

    // Warm-up, then zero coefficients.
    add_sample(S_MIN, 1'b1, '0);
    add_sample(S_MAX, 1'b1, '0);
    add_sample(16'sd12345, 1'b1, '0);
    // Unity gain passes the rails straight through.
    add_write(CFG_B0, C_ONE);
    add_sample(S_MAX, 1'b1, S_MAX);
    add_sample(S_MIN, 1'b1, S_MIN);
    add_sample(-16'sd1, 1'b1, -16'sd1);
    // Largest gain: truncation toward zero on small inputs, saturation on large ones.
    add_write(CFG_B0, C_MAX);
    add_sample(16'sd1, 1'b1, 16'sd7);
    add_sample(-16'sd1, 1'b1, -16'sd7);
    add_sample(S_MAX, 1'b1, S_MAX);
    add_sample(S_MIN, 1'b1, S_MIN);
    // Most negative gain flips the rails.
    add_write(CFG_B0, C_MIN);
    add_sample(S_MIN, 1'b1, S_MAX);
    add_sample(S_MAX, 1'b1, S_MIN);
    add_sample('0, 1'b1, '0);
    // Extreme taps with feedback through both sections; upper data bits are ignored.
    add_write(CFG_B0, C_ONE);
    add_write(CFG_B1, C_MAX);
    add_write(CFG_B2, C_MIN);
    add_write(CFG_A1, C_MAX);
    add_write(CFG_A2, C_MIN);
    add_write(CFG_TWO_SECTIONS, 20'hFFFFF);
    add_sample(16'sd100, 1'b0, '0);
    add_sample(-16'sd100, 1'b0, '0);
    add_sample(S_MAX, 1'b0, '0);
    add_sample(S_MIN, 1'b0, '0);
    // Second section off holds its history; spare indexes do nothing.
    add_write(CFG_TWO_SECTIONS, 20'hFFFFE);
    add_write(CFG_SPARE_LO, 20'hFFFFF);
    add_write(CFG_SPARE_HI, 20'h5A5A5);
    add_write(CFG_A1, 20'h08000);
    add_write(CFG_A2, '0);
    add_sample(16'sd1000, 1'b0, '0);
    add_sample(-16'sd1000, 1'b0, '0);
    add_sample(16'sd5, 1'b0, '0);
    // Second section resumes from the history it held.
    add_write(CFG_TWO_SECTIONS, 20'h00001);
    add_sample(16'sd2000, 1'b0, '0);
    add_sample(-16'sd3, 1'b0, '0);
    add_sample('0, 1'b0, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_sample(dir_rows[i].x, dir_rows[i].typed, dir_rows[i].want);
      end
    end
    settings_used++;

    // Random phases, each with its own coefficient set.
    while (samples_sent < RANDOM_TARGET) begin
      configure_phase();
      if (phase == 1) hold_req = 1'b1;
      if (samples_sent > RANDOM_TARGET - 150) begin
        calm       = 1'b1;
        idle_level = 0;
      end
      n = $urandom_range(60, 140);
      repeat (n) send_sample(pick_sample(), 1'b0, '0);
      phase++;
    end

    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered warm-up, rounding and saturation extremes, spare register writes and");
    $display("%0d coefficient settings: %0d samples sent, %0d filtered samples checked.",
             settings_used, samples_sent, samples_checked);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/cbq_pkg.sv
rtl/core/cbq_ctrl.sv
rtl/core/cbq_datapath.sv
rtl/core/cascaded_biquad_iir_filter.sv
bench/tb.sv
